>>> hdl/pdpc_pkg.sv
// Shared types, constants and the step program of the PD position loop.
// No dependencies; imported by pdpc_datapath and pd_position_control.
package pdpc_pkg;

   // field and register widths
   localparam int GAIN_W   = 16;
   localparam int PERIOD_W = 15;
   localparam int SPAN_W   = 17;
   localparam int RAW_W    = 16;
   localparam int POS_W    = 32;
   localparam int DUTY_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   // internal widths
   localparam int SPROD_W = 34;   // rollovers x span
   localparam int WIDE_W  = 35;   // sums ahead of saturation
   localparam int DE_W    = 33;   // error difference
   localparam int P1_W    = 48;   // kp x error
   localparam int P2_W    = 49;   // kd x error difference
   localparam int ACC_W   = 50;
   localparam int MAG_W   = 8;    // magnitude below the cap
   localparam int SCALE_W = 23;   // magnitude x period, magnitude below the cap
   localparam int QUOT_W  = 17;

   localparam int GAIN_FRAC_BITS_DEF = 8;

   // any magnitude at or above this saturates duty at the full period
   localparam int MAG_CAP = 200;

   // divide by 100 as multiply by reciprocal, exact for inputs below 2^23
   localparam int RECIP_SHIFT = 30;
   localparam int RECIP_W     = 24;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 24'd10737419;
   localparam int RPROD_W = SCALE_W + RECIP_W;

   localparam logic [RAW_W-1:0] RAW_MID = 16'h8000;

   // input operations
   localparam logic OP_STEP = 1'b0;
   localparam logic OP_ROLL = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_PERIOD = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLL_SPAN  = 2'd3;

   localparam logic [GAIN_W-1:0]   PROP_GAIN_RST  = 16'd256;
   localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST = 16'd0;
   localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST = 15'd1000;
   localparam logic [SPAN_W-1:0]   ROLL_SPAN_RST  = 17'd32768;

   // micro-operations
   localparam int UOP_W = 4;
   localparam logic [UOP_W-1:0] UOP_NOP   = 4'd0;
   localparam logic [UOP_W-1:0] UOP_SPAN  = 4'd1;
   localparam logic [UOP_W-1:0] UOP_POS   = 4'd2;
   localparam logic [UOP_W-1:0] UOP_ERR   = 4'd3;
   localparam logic [UOP_W-1:0] UOP_KP    = 4'd4;
   localparam logic [UOP_W-1:0] UOP_KD    = 4'd5;
   localparam logic [UOP_W-1:0] UOP_ACC   = 4'd6;
   localparam logic [UOP_W-1:0] UOP_MAG   = 4'd7;
   localparam logic [UOP_W-1:0] UOP_SCALE = 4'd8;
   localparam logic [UOP_W-1:0] UOP_RECIP = 4'd9;
   localparam logic [UOP_W-1:0] UOP_EMIT  = 4'd10;
   localparam logic [UOP_W-1:0] UOP_ROLL  = 4'd11;

   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] ADDR_START = 4'd0;
   localparam logic [PC_W-1:0] ADDR_ROLL  = 4'd10;

   typedef struct packed {
      logic [UOP_W-1:0] uop;
      logic             jump_roll;   // jump when the item is a rollover event
      logic [PC_W-1:0]  jump_addr;
      logic             last;
   } ucode_type;

   // control from the sequencer to the datapath
   typedef struct packed {
      logic             load_req;
      logic             exec;
      logic [UOP_W-1:0] uop;
   } ctrl_type;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] addr);
      ucode_type w;
      w = '{uop: UOP_NOP, jump_roll: 1'b0, jump_addr: ADDR_START, last: 1'b1};
      case (addr)
         4'd0: w = '{uop: UOP_SPAN,  jump_roll: 1'b1, jump_addr: ADDR_ROLL,  last: 1'b0};
         4'd1: w = '{uop: UOP_POS,   jump_roll: 1'b0, jump_addr: ADDR_START, last: 1'b0};
         4'd2: w = '{uop: UOP_ERR,   jump_roll: 1'b0, jump_addr: ADDR_START, last: 1'b0};
         4'd3: w = '{uop: UOP_KP,    jump_roll: 1'b0, jump_addr: ADDR_START, last: 1'b0};
         4'd4: w = '{uop: UOP_KD,    jump_roll: 1'b0, jump_addr: ADDR_START, last: 1'b0};
         4'd5: w = '{uop: UOP_ACC,   jump_roll: 1'b0, jump_addr: ADDR_START, last: 1'b0};
         4'd6: w = '{uop: UOP_MAG,   jump_roll: 1'b0, jump_addr: ADDR_START, last: 1'b0};
         4'd7: w = '{uop: UOP_SCALE, jump_roll: 1'b0, jump_addr: ADDR_START, last: 1'b0};
         4'd8: w = '{uop: UOP_RECIP, jump_roll: 1'b0, jump_addr: ADDR_START, last: 1'b0};
         4'd9: w = '{uop: UOP_EMIT,  jump_roll: 1'b0, jump_addr: ADDR_START, last: 1'b1};
         4'd10: w = '{uop: UOP_ROLL, jump_roll: 1'b0, jump_addr: ADDR_START, last: 1'b1};
         default: w = '{uop: UOP_NOP, jump_roll: 1'b0, jump_addr: ADDR_START, last: 1'b1};
      endcase
      return w;
   endfunction

   // clamp a 35-bit signed value into 32 bits
   function automatic logic signed [POS_W-1:0] sat_to32(input logic signed [WIDE_W-1:0] v);
      if (v[WIDE_W-1] && !(&v[WIDE_W-2:POS_W-1]))
         return $signed({1'b1, {(POS_W-1){1'b0}}});
      else if (!v[WIDE_W-1] && (|v[WIDE_W-2:POS_W-1]))
         return $signed({1'b0, {(POS_W-1){1'b1}}});
      else
         return $signed(v[POS_W-1:0]);
   endfunction

endpackage

>>> hdl/pdpc_datapath.sv
// Datapath of the PD position loop: one micro-operation per enabled cycle.
// Holds the rollover count and last error. Depends on pdpc_pkg.
module pdpc_datapath #(
   parameter int GAIN_FRAC_BITS = pdpc_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pdpc_pkg::ctrl_type                    ctrl,
   input  logic [pdpc_pkg::RAW_W-1:0]            req_raw_count,
   input  logic                                  req_count_up,
   input  logic signed [pdpc_pkg::POS_W-1:0]     req_target_pulses,
   input  logic signed [pdpc_pkg::GAIN_W-1:0]    prop_gain,
   input  logic signed [pdpc_pkg::GAIN_W-1:0]    deriv_gain,
   input  logic [pdpc_pkg::PERIOD_W-1:0]         pwm_period,
   input  logic [pdpc_pkg::SPAN_W-1:0]           rollover_span,
   output logic                                  reverse,
   output logic [pdpc_pkg::DUTY_W-1:0]           duty_compare,
   output logic signed [pdpc_pkg::POS_W-1:0]     position
);
   import pdpc_pkg::*;

   localparam logic signed [ACC_W-1:0] CapPos = ACC_W'(MAG_CAP);
   localparam logic signed [ACC_W-1:0] CapNeg = -CapPos;

   logic [RAW_W-1:0]           raw_ff;
   logic                       up_ff;
   logic signed [POS_W-1:0]    target_ff;

   logic signed [RAW_W-1:0]    rollovers_ff, rollovers_in;
   logic signed [POS_W-1:0]    last_error_ff, last_error_in;

   logic signed [SPROD_W-1:0]  sprod_ff, sprod_in;
   logic signed [POS_W-1:0]    pos_ff, pos_in;
   logic signed [POS_W-1:0]    err_ff, err_in;
   logic signed [P1_W-1:0]     p1_ff, p1_in;
   logic signed [DE_W-1:0]     de_ff, de_in;
   logic signed [P2_W-1:0]     p2_ff, p2_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic                       neg_ff, neg_in;
   logic                       big_ff, big_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic [SCALE_W-1:0]         scaled_ff, scaled_in;
   logic [QUOT_W-1:0]          quot_ff, quot_in;

   logic signed [RAW_W-1:0]    counter;
   logic signed [WIDE_W-1:0]   pos_sum;
   logic signed [WIDE_W-1:0]   err_diff;
   logic signed [ACC_W-1:0]    drive;
   logic [MAG_W:0]             drive_neg_low;
   logic [RPROD_W-1:0]         recip_prod;
   logic [PERIOD_W-1:0]        duty;

   assign counter   = $signed(raw_ff ^ RAW_MID);
   assign pos_sum   = WIDE_W'(counter) + WIDE_W'(sprod_ff);
   assign err_diff  = WIDE_W'(target_ff) - WIDE_W'(pos_ff);
   assign drive     = acc_ff >>> GAIN_FRAC_BITS;
   assign drive_neg_low = (MAG_W+1)'(0) - drive[MAG_W:0];
   assign recip_prod = RPROD_W'(scaled_ff) * RPROD_W'(RECIP_MULT);

   assign sprod_in  = SPROD_W'(rollovers_ff) * $signed(SPROD_W'(rollover_span));
   assign pos_in    = sat_to32(pos_sum);
   assign err_in    = sat_to32(err_diff);
   assign p1_in     = P1_W'(prop_gain) * P1_W'(err_ff);
   assign de_in     = DE_W'(err_ff) - DE_W'(last_error_ff);
   assign p2_in     = P2_W'(deriv_gain) * P2_W'(de_ff);
   assign acc_in    = ACC_W'(p1_ff) - ACC_W'(p2_ff);
   assign neg_in    = drive[ACC_W-1];
   assign big_in    = (drive >= CapPos) || (drive <= CapNeg);
   assign mag_in    = neg_in ? drive_neg_low[MAG_W-1:0] : drive[MAG_W-1:0];
   assign scaled_in = SCALE_W'(mag_ff) * SCALE_W'(pwm_period);
   assign quot_in   = QUOT_W'(recip_prod >> RECIP_SHIFT);

   // cap at the full period
   assign duty = (big_ff || (quot_ff > QUOT_W'(pwm_period))) ? pwm_period
                                                            : PERIOD_W'(quot_ff);

   assign reverse      = neg_ff;
   assign duty_compare = {duty, 1'b0};
   assign position     = pos_ff;

   always_comb begin
      rollovers_in  = rollovers_ff;
      last_error_in = last_error_ff;
      if (ctrl.exec && ctrl.uop == UOP_ROLL) begin
         rollovers_in = up_ff ? rollovers_ff + 16'sd1 : rollovers_ff - 16'sd1;
      end
      if (ctrl.exec && ctrl.uop == UOP_EMIT) begin
         last_error_in = err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rollovers_ff  <= '0;
         last_error_ff <= '0;
      end else begin
         rollovers_ff  <= rollovers_in;
         last_error_ff <= last_error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_req) begin
         raw_ff    <= req_raw_count;
         up_ff     <= req_count_up;
         target_ff <= req_target_pulses;
      end
      if (ctrl.exec) begin
         case (ctrl.uop)
            UOP_SPAN:  sprod_ff <= sprod_in;
            UOP_POS:   pos_ff   <= pos_in;
            UOP_ERR:   err_ff   <= err_in;
            UOP_KP: begin
               p1_ff <= p1_in;
               de_ff <= de_in;
            end
            UOP_KD:    p2_ff    <= p2_in;
            UOP_ACC:   acc_ff   <= acc_in;
            UOP_MAG: begin
               neg_ff <= neg_in;
               big_ff <= big_in;
               mag_ff <= mag_in;
            end
            UOP_SCALE: scaled_ff <= scaled_in;
            UOP_RECIP: quot_ff   <= quot_in;
            default: ;
         endcase
      end
   end

endmodule

>>> hdl/pd_position_control.sv
// Top level of the PD position loop: handshakes, register file, step sequencer.
// Depends on pdpc_pkg and pdpc_datapath.
//
//   channel | ports                                          | direction
//   --------+------------------------------------------------+----------
//   req     | op, raw_count, count_up, target_pulses         | in
//   rsp     | reverse, duty_compare, position                | out
//   csr     | index (0 kp, 1 kd, 2 period, 3 span), data     | in
//
// A control step runs 10 program steps after acceptance, one per cycle unless the
// result step stalls; the steps are set by the chain of dependent multiplies in the
// datapath. A new item is taken the cycle after the last step.
// A rollover event runs 2 steps.
// Reset clears sequencer, rollover count and last error; registers get defaults.
// The result step holds while the output register is full and not being taken.
module pd_position_control #(
   parameter int GAIN_FRAC_BITS = pdpc_pkg::GAIN_FRAC_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_op,
   input  logic [pdpc_pkg::RAW_W-1:0]             req_raw_count,
   input  logic                                   req_count_up,
   input  logic signed [pdpc_pkg::POS_W-1:0]      req_target_pulses,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_reverse,
   output logic [pdpc_pkg::DUTY_W-1:0]            rsp_duty_compare,
   output logic signed [pdpc_pkg::POS_W-1:0]      rsp_position,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [pdpc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [pdpc_pkg::CSR_DATA_W-1:0]        csr_data
);
   import pdpc_pkg::*;

   logic signed [GAIN_W-1:0] prop_gain_ff;
   logic signed [GAIN_W-1:0] deriv_gain_ff;
   logic [PERIOD_W-1:0]      pwm_period_ff;
   logic [SPAN_W-1:0]        rollover_span_ff;

   logic                     busy_ff, busy_in;
   logic [PC_W-1:0]          pc_ff, pc_in;
   logic                     op_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_reverse_ff;
   logic [DUTY_W-1:0]        rsp_duty_ff;
   logic signed [POS_W-1:0]  rsp_position_ff;

   ucode_type                uword;
   ctrl_type                 ctrl;
   logic                     req_fire;
   logic                     stall;
   logic                     emit_fire;

   logic                     dp_reverse;
   logic [DUTY_W-1:0]        dp_duty;
   logic signed [POS_W-1:0]  dp_position;

   assign csr_ready = 1'b1;
   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;

   assign uword     = ucode_rom(pc_ff);
   // hold the result step until the output register frees up
   assign stall     = (uword.uop == UOP_EMIT) && rsp_valid_ff && !rsp_ready;
   assign emit_fire = busy_ff && !stall && (uword.uop == UOP_EMIT);

   assign ctrl = '{load_req: req_fire, exec: busy_ff && !stall, uop: uword.uop};

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (req_fire) begin
         busy_in = 1'b1;
         pc_in   = ADDR_START;
      end else if (busy_ff && !stall) begin
         if (uword.last) begin
            busy_in = 1'b0;
            pc_in   = ADDR_START;
         end else if (uword.jump_roll && op_ff == OP_ROLL) begin
            pc_in = uword.jump_addr;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   assign rsp_valid_in = emit_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= ADDR_START;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff <= req_op;
      end
      if (emit_fire) begin
         rsp_reverse_ff  <= dp_reverse;
         rsp_duty_ff     <= dp_duty;
         rsp_position_ff <= dp_position;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= PROP_GAIN_RST;
         deriv_gain_ff    <= DERIV_GAIN_RST;
         pwm_period_ff    <= PWM_PERIOD_RST;
         rollover_span_ff <= ROLL_SPAN_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PROP_GAIN:  prop_gain_ff     <= $signed(csr_data[GAIN_W-1:0]);
            CSR_DERIV_GAIN: deriv_gain_ff    <= $signed(csr_data[GAIN_W-1:0]);
            CSR_PWM_PERIOD: pwm_period_ff    <= csr_data[PERIOD_W-1:0];
            CSR_ROLL_SPAN:  rollover_span_ff <= csr_data[SPAN_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_reverse      = rsp_reverse_ff;
   assign rsp_duty_compare = rsp_duty_ff;
   assign rsp_position     = rsp_position_ff;

   pdpc_datapath #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .req_raw_count     (req_raw_count),
      .req_count_up      (req_count_up),
      .req_target_pulses (req_target_pulses),
      .prop_gain         (prop_gain_ff),
      .deriv_gain        (deriv_gain_ff),
      .pwm_period        (pwm_period_ff),
      .rollover_span     (rollover_span_ff),
      .reverse           (dp_reverse),
      .duty_compare      (dp_duty),
      .position          (dp_position)
   );

endmodule
